/* design/tama_pkg.sv */
// Shared types and constants of the three-axis moving average.
// No dependencies; every other design file imports this package.
`default_nettype none

package tama_pkg;

  localparam int SMP_W          = 16;    // sample and mean width
  localparam int SUM_W          = 26;    // running sum width per axis
  localparam int WIN_W          = 10;    // window register width
  localparam int NUM_AX         = 3;     // x, y, z
  localparam int RING_DEPTH_DEF = 1024;  // default ring store depth
  localparam int QUEUE_DEPTH    = 2;     // entries between front and back
  localparam int CNT_W          = $clog2(SUM_W);

  // One job handed from the front to the back: three sums and their divisor.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [WIN_W-1:0]        window;
  } tama_entry_t;

endpackage

`default_nettype wire

/* design/tama_in_if.sv */
// Sample channel: valid/ready handshake carrying one sample per axis.
// Depends on tama_pkg for the field widths.
`default_nettype none

interface tama_in_if;
  import tama_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_x;
  logic signed [SMP_W-1:0] sample_y;
  logic signed [SMP_W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

`default_nettype wire

/* design/tama_out_if.sv */
// Result channel: valid/ready handshake carrying one mean per axis.
// Depends on tama_pkg for the field widths.
`default_nettype none

interface tama_out_if;
  import tama_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] mean_x;
  logic signed [SMP_W-1:0] mean_y;
  logic signed [SMP_W-1:0] mean_z;

  modport source (output valid, output mean_x, output mean_y, output mean_z,
                  input ready);
  modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                  output ready);
endinterface

`default_nettype wire

/* design/three_axis_moving_average.sv */
// Three-axis moving average: from sample transfer to result valid a sample passes
// the front-end sum step, the queue step, the divider steps and the finish step.
// Throughput is bounded by the bit-serial divider, which works the sums of a job (one
// quotient bit per cycle over the 26-bit sum). Reset and every window write clear
// the sums, head and fill count, no clearing pass; reset sets the window to 1.
`default_nettype none

module three_axis_moving_average #(
  parameter int RING_DEPTH = tama_pkg::RING_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tama_pkg::WIN_W-1:0] cfg_wdata,
  tama_in_if.sink                    in_ch,
  tama_out_if.source                 out_ch
);
  import tama_pkg::*;

  logic        push_valid, push_ready, pop_valid, pop_ready;
  tama_entry_t push_data, pop_data;

  tama_front #(
    .RING_DEPTH (RING_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tama_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tama_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* design/tama_front.sv */
// Front end: takes samples, keeps the ring store and the running sums,
// and pushes one divide job per sample. Depends on tama_pkg and tama_in_if.
`default_nettype none

module tama_front #(
  parameter int RING_DEPTH = tama_pkg::RING_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [tama_pkg::WIN_W-1:0] cfg_wdata,
  tama_in_if.sink                   in_ch,
  output logic                      push_valid,
  input  logic                      push_ready,
  output tama_pkg::tama_entry_t     push_data
);
  import tama_pkg::*;

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int RW = NUM_AX * SMP_W;

  typedef enum logic {F_IDLE, F_SUM} fstate_t;

  fstate_t                 state_r, state_nxt;
  logic [AW-1:0]           head_r, head_nxt, old_addr;
  logic [WIN_W-1:0]        win_r, win_nxt, fill_r, fill_nxt, win_clamp;
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic signed [SUM_W-1:0] new_sum_x, new_sum_y, new_sum_z;
  logic [RW-1:0]           ring [RING_DEPTH];
  logic [RW-1:0]           rd_data_r, smp_r;
  logic                    old_ok_r;
  logic                    accept;
  logic [CW-1:0]           head_ext, win_ext, wdata_ext, old_ext;
  logic signed [SMP_W-1:0] old_x, old_y, old_z;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the written window into 1 .. RING_DEPTH-1.
  always_comb begin
    wdata_ext = CW'(cfg_wdata);
    if (wdata_ext == '0) begin
      win_clamp = WIN_W'(1);
    end else if (wdata_ext > CW'(RING_DEPTH - 1)) begin
      win_clamp = WIN_W'(RING_DEPTH - 1);
    end else begin
      win_clamp = WIN_W'(wdata_ext);
    end
  end

  // Oldest sample still in the window sits window positions behind the head.
  always_comb begin
    head_ext = CW'(head_r);
    win_ext  = CW'(win_r);
    if (head_ext >= win_ext) begin
      old_ext = head_ext - win_ext;
    end else begin
      old_ext = head_ext + CW'(RING_DEPTH) - win_ext;
    end
    old_addr = AW'(old_ext);
  end

  // Entries not written since the last clear read as zero.
  assign old_x = old_ok_r ? $signed(rd_data_r[3*SMP_W-1:2*SMP_W]) : '0;
  assign old_y = old_ok_r ? $signed(rd_data_r[2*SMP_W-1:SMP_W])   : '0;
  assign old_z = old_ok_r ? $signed(rd_data_r[SMP_W-1:0])         : '0;

  assign new_sum_x = sum_x_r + SUM_W'($signed(smp_r[3*SMP_W-1:2*SMP_W])) - SUM_W'(old_x);
  assign new_sum_y = sum_y_r + SUM_W'($signed(smp_r[2*SMP_W-1:SMP_W]))   - SUM_W'(old_y);
  assign new_sum_z = sum_z_r + SUM_W'($signed(smp_r[SMP_W-1:0]))         - SUM_W'(old_z);

  assign push_valid       = (state_r == F_SUM);
  assign push_data.sum_x  = new_sum_x;
  assign push_data.sum_y  = new_sum_y;
  assign push_data.sum_z  = new_sum_z;
  assign push_data.window = win_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    if (cfg_we) begin
      // new window: restart with an empty store
      win_nxt   = win_clamp;
      head_nxt  = '0;
      fill_nxt  = '0;
      sum_x_nxt = '0;
      sum_y_nxt = '0;
      sum_z_nxt = '0;
      state_nxt = F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_nxt = F_SUM;
          end
        end
        F_SUM: begin
          if (push_ready) begin
            sum_x_nxt = new_sum_x;
            sum_y_nxt = new_sum_y;
            sum_z_nxt = new_sum_z;
            head_nxt  = (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + AW'(1);
            if (fill_r < win_r) begin
              fill_nxt = fill_r + WIN_W'(1);
            end
            state_nxt = F_IDLE;
          end
        end
        default: state_nxt = F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      head_r  <= '0;
      win_r   <= WIN_W'(1);
      fill_r  <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
    end
  end

  // Ring store: write the new sample at the head, read the oldest one.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[head_r] <= {in_ch.sample_x, in_ch.sample_y, in_ch.sample_z};
      rd_data_r    <= ring[old_addr];
      smp_r        <= {in_ch.sample_x, in_ch.sample_y, in_ch.sample_z};
      old_ok_r     <= (fill_r >= win_r);
    end
  end

  a_fill_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r)
    else $error("fill count exceeds window");

  a_win_range: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != '0) && (CW'(win_r) <= CW'(RING_DEPTH - 1)))
    else $error("window out of range");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(head_r) <= CW'(RING_DEPTH - 1))
    else $error("head pointer beyond ring");

  a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_we) |=> push_valid)
    else $error("accepted sample not pushed");

endmodule

`default_nettype wire

/* design/tama_fifo.sv */
// Short job queue between the front end and the divider back end.
// Depends on tama_pkg for the entry type and depth.
`default_nettype none

module tama_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  tama_pkg::tama_entry_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output tama_pkg::tama_entry_t pop_data
);
  import tama_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  tama_entry_t   q_mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          push, pop;

  assign push_ready = (count_r < (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/tama_back.sv */
// Back end: three bit-serial restoring dividers, one per axis, and the
// result register. Depends on tama_pkg and tama_out_if.
`default_nettype none

module tama_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  tama_pkg::tama_entry_t pop_data,
  tama_out_if.source            out_ch
);
  import tama_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} bstate_t;

  bstate_t                 state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [WIN_W-1:0]        div_r, div_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]        quo_r [NUM_AX];
  logic [SUM_W-1:0]        quo_nxt [NUM_AX];
  logic [WIN_W-1:0]        rem_r [NUM_AX];
  logic [WIN_W-1:0]        rem_nxt [NUM_AX];
  logic                    neg_r [NUM_AX];
  logic                    neg_nxt [NUM_AX];
  logic signed [SMP_W-1:0] mean_r [NUM_AX];
  logic signed [SMP_W-1:0] mean_nxt [NUM_AX];
  logic signed [SUM_W-1:0] ent_sum [NUM_AX];
  logic [WIN_W:0]          shifted [NUM_AX];
  logic [SUM_W-1:0]        res [NUM_AX];
  logic                    rem_ok;

  assign ent_sum[0] = pop_data.sum_x;
  assign ent_sum[1] = pop_data.sum_y;
  assign ent_sum[2] = pop_data.sum_z;

  assign pop_ready    = (state_r == B_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.mean_x = mean_r[0];
  assign out_ch.mean_y = mean_r[1];
  assign out_ch.mean_z = mean_r[2];

  always_comb begin
    for (int i = 0; i < NUM_AX; i++) begin
      shifted[i] = {rem_r[i], quo_r[i][SUM_W-1]};
      res[i]     = neg_r[i] ? -quo_r[i] : quo_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    div_nxt       = div_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    for (int i = 0; i < NUM_AX; i++) begin
      quo_nxt[i]  = quo_r[i];
      rem_nxt[i]  = rem_r[i];
      neg_nxt[i]  = neg_r[i];
      mean_nxt[i] = mean_r[i];
    end
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          // divide magnitudes, restore the sign at the end
          for (int i = 0; i < NUM_AX; i++) begin
            neg_nxt[i] = ent_sum[i][SUM_W-1];
            quo_nxt[i] = ent_sum[i][SUM_W-1] ? SUM_W'(-ent_sum[i]) : SUM_W'(ent_sum[i]);
            rem_nxt[i] = '0;
          end
          div_nxt   = pop_data.window;
          cnt_nxt   = CNT_W'(SUM_W - 1);
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        for (int i = 0; i < NUM_AX; i++) begin
          if (shifted[i] >= {1'b0, div_r}) begin
            rem_nxt[i] = WIN_W'(shifted[i] - {1'b0, div_r});
            quo_nxt[i] = {quo_r[i][SUM_W-2:0], 1'b1};
          end else begin
            rem_nxt[i] = shifted[i][WIN_W-1:0];
            quo_nxt[i] = {quo_r[i][SUM_W-2:0], 1'b0};
          end
        end
        if (cnt_r == '0) begin
          state_nxt = B_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      B_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          for (int i = 0; i < NUM_AX; i++) begin
            mean_nxt[i] = $signed(res[i][SMP_W-1:0]);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    div_r <= div_nxt;
    for (int i = 0; i < NUM_AX; i++) begin
      quo_r[i]  <= quo_nxt[i];
      rem_r[i]  <= rem_nxt[i];
      neg_r[i]  <= neg_nxt[i];
      mean_r[i] <= mean_nxt[i];
    end
  end

  assign rem_ok = (rem_r[0] < div_r) && (rem_r[1] < div_r) && (rem_r[2] < div_r);

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> rem_ok)
    else $error("partial remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> (div_r != '0))
    else $error("zero divisor in use");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == B_DONE))
    else $error("result raised outside the finish step");

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// Testbench of three_axis_moving_average: directed and random samples through the sample
// channel, each mean checked against a running-window predictor kept here.
// Depends on tama_pkg, tama_in_if, tama_out_if and the block itself.

module tb;
  import tama_pkg::*;

  localparam int DEPTH        = RING_DEPTH_DEF;
  localparam int MAX_GAP      = 12;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [SMP_W-1:0] SMP_MAX = 16'h7FFF;
  localparam logic [SMP_W-1:0] SMP_MIN = 16'h8000;

  // Element 0 is x, 1 is y, 2 is z.
  typedef logic [NUM_AX-1:0][SMP_W-1:0] axes_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;

  tama_in_if  in_ch();
  tama_out_if out_ch();

  three_axis_moving_average i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: sample history, head, per-axis window sums and the window.
  axes_t                   history [DEPTH];
  int                      head;
  int                      window;
  logic signed [SUM_W-1:0] axis_sum [NUM_AX];

  axes_t pending_means[$];
  int    mismatch_count = 0;
  logic  idle_en = 1'b1;
  int    stall_left;
  string axis_tag = "xyz";

  function automatic void clear_history();
    for (int i = 0; i < DEPTH; i++) history[i] = '0;
    for (int a = 0; a < NUM_AX; a++) axis_sum[a] = '0;
    head = 0;
  endfunction

  function automatic int clamp_window(logic [WIN_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > DEPTH - 1) return DEPTH - 1;
    return int'(v);
  endfunction

  // Store the sample, slide each sum by one and divide, truncating toward zero.
  function automatic axes_t next_means(axes_t smp);
    int    oldest;
    int    quo;
    axes_t res;
    history[head] = smp;
    oldest = (head + DEPTH - window) % DEPTH;
    for (int a = 0; a < NUM_AX; a++) begin
      axis_sum[a] = axis_sum[a] + $signed(smp[a]) - $signed(history[oldest][a]);
      quo = int'(axis_sum[a]) / window;
      res[a] = quo[SMP_W-1:0];
    end
    head = (head + 1) % DEPTH;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Follow window writes and sample transfers; check every result transfer.
  always @(posedge clk) begin
    axes_t got;
    axes_t want;
    if (!rst_n) begin
      window = 1;
      clear_history();
    end else begin
      if (cfg_we) begin
        window = clamp_window(cfg_wdata);
        clear_history();
      end
      if (in_ch.valid && in_ch.ready)
        pending_means.push_back(next_means({in_ch.sample_z, in_ch.sample_y, in_ch.sample_x}));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.mean_z, out_ch.mean_y, out_ch.mean_x};
        if (pending_means.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d %0d %0d",
                                    $signed(got[0]), $signed(got[1]), $signed(got[2])));
        end else begin
          want = pending_means.pop_front();
          for (int a = 0; a < NUM_AX; a++)
            if (got[a] !== want[a])
              report_mismatch($sformatf("mean_%c: got %0d, expected %0d", axis_tag[a],
                                        $signed(got[a]), $signed(want[a])));
        end
      end
    end
  end

  // Result side: while idle_en is set, stall a random number of cycles after each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        stall_left = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic axes_t axes(logic [SMP_W-1:0] x, logic [SMP_W-1:0] y,
                                 logic [SMP_W-1:0] z);
    return {z, y, x};
  endfunction

  // Mostly the extreme of the given sign, now and then anything.
  function automatic logic [SMP_W-1:0] leaning_sample(bit positive);
    logic [SMP_W-1:0] r;
    r = SMP_W'($urandom());
    if ($urandom_range(0, 7) == 0) return r;
    return positive ? SMP_MAX : SMP_MIN;
  endfunction

  function automatic logic [SMP_W-1:0] mixed_sample();
    logic [SMP_W-1:0] r;
    r = SMP_W'($urandom());
    case ($urandom_range(0, 7))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return r >>> 12;
      default: return r;
    endcase
  endfunction

  task automatic send_sample(input axes_t smp);
    int gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample_x <= smp[0];
    in_ch.sample_y <= smp[1];
    in_ch.sample_z <= smp[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every pending mean has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_field_extremes();
    send_sample(axes(SMP_MAX, SMP_MIN, 16'h0000));
    send_sample(axes(SMP_MIN, SMP_MAX, 16'hFFFF));
    send_sample(axes(16'h0000, 16'hFFFF, 16'h0001));
    send_sample(axes(16'hFFFF, 16'h0000, SMP_MAX));
    send_sample(axes(16'h5555, 16'hAAAA, 16'h00FF));
    send_sample(axes(16'hAAAA, 16'h5555, 16'hFF00));
    wait_drained();
  endtask

  // A zero window is taken as one; a write also clears the history.
  task automatic test_window_clamp();
    write_window(WIN_W'(2));
    send_sample(axes(SMP_MAX, SMP_MIN, 16'd100));
    send_sample(axes(16'd1, 16'd1, 16'd1));
    wait_drained();
    write_window(WIN_W'(0));
    send_sample(axes(SMP_MIN, SMP_MAX, -16'sd7));
    send_sample(axes(16'd3, -16'sd3, 16'd0));
    send_sample(axes(SMP_MAX, SMP_MAX, SMP_MAX));
    wait_drained();
  endtask

  // Negative sums must round toward zero; a rewrite of the same window clears.
  task automatic test_truncation();
    write_window(WIN_W'(3));
    send_sample(axes(-16'sd1, 16'd1, SMP_MIN));
    send_sample(axes(-16'sd1, 16'd1, SMP_MIN));
    send_sample(axes(16'd5, -16'sd5, 16'd2));
    send_sample(axes(16'd0, 16'd0, 16'd0));
    wait_drained();
    write_window(WIN_W'(3));
    send_sample(axes(-16'sd2, 16'd2, 16'd1));
    send_sample(axes(16'd0, 16'd0, 16'd0));
    send_sample(axes(16'd0, -16'sd1, 16'd0));
    wait_drained();
  endtask

  // Largest window, past a full wrap of the history, near full-scale sums.
  task automatic test_full_window();
    bit positive;
    write_window(WIN_W'(DEPTH - 1));
    for (int i = 0; i < 1100; i++) begin
      idle_en  = (i < 300) || (i >= 700);
      positive = (i < DEPTH);
      send_sample(axes(leaning_sample(positive), leaning_sample(!positive),
                       SMP_W'($urandom())));
    end
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random_windows();
    logic [WIN_W-1:0] windows [6];
    windows[0] = WIN_W'(1);
    windows[1] = WIN_W'(DEPTH - 2);
    windows[2] = WIN_W'(2);
    windows[3] = WIN_W'($urandom_range(3, 40));
    windows[4] = WIN_W'($urandom_range(41, DEPTH - 3));
    windows[5] = WIN_W'(0);
    for (int p = 0; p < 6; p++) begin
      idle_en = ($urandom_range(0, 3) != 0);
      write_window(windows[p]);
      for (int i = 0; i < 80; i++)
        send_sample(axes(mixed_sample(), mixed_sample(), mixed_sample()));
      wait_drained();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    out_ch.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_window_clamp();
    test_truncation();
    test_full_window();
    test_random_windows();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_means.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d means pending", pending_means.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
